>>> rtl/integer_to_ascii_formatter_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter macros
// assertion helpers used by the formatter datapath (itaf_dpath)
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`ifndef ASSERT_OFF
`define ITAF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ITAF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ITAF_ASSERT(lbl, clk, rstn, prop, msg)
`define ITAF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// types, constants and codes shared by the integer to ascii formatter
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int unsigned MaxFieldWidthDef = 32;
  localparam int unsigned ValueWidth       = 64;
  localparam int unsigned BcdDigits        = 20;
  localparam int unsigned BitsPerStep      = 4;
  localparam int unsigned ConvSteps        = ValueWidth / BitsPerStep;

  localparam int unsigned FlagHex       = 0;
  localparam int unsigned FlagSigned    = 1;
  localparam int unsigned FlagLower     = 2;
  localparam int unsigned FlagPadBefore = 3;
  localparam int unsigned FlagPadZero   = 4;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharSpace  = 8'h20;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  field_width;
    logic [4:0]  format_flags;
  } itaf_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } itaf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP_CNT,
    ST_PREP_PAD,
    ST_LEAD,
    ST_PADPRE,
    ST_SIGN,
    ST_DIGITS,
    ST_PADPOST
  } itaf_state_e;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_PAD,
    SEL_DIGIT
  } itaf_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      prep_cnt;
    logic      prep_pad;
    logic      emit;
    itaf_sel_e sel;
    logic      last;
  } itaf_cmd_t;

  typedef struct packed {
    logic hex;
    logic conv_last;
    logic lead_sign;
    logic inline_sign;
    logic pad_before;
    logic pad_left;
    logic pad_one;
    logic dig_last;
    logic out_free;
  } itaf_sts_t;

endpackage

>>> rtl/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl
// sequencer: conversion, field setup and character emission order
// ----------------------------------------------------------------------------
module itaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itaf_pkg::itaf_sts_t sts_i,
  output itaf_pkg::itaf_cmd_t cmd_o
);
  import itaf_pkg::*;

  itaf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_PAD;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.hex ? ST_PREP_CNT : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_PREP_CNT;
        end
      end
      ST_PREP_CNT: begin
        cmd_o.prep_cnt = 1'b1;
        state_d        = ST_PREP_PAD;
      end
      ST_PREP_PAD: begin
        cmd_o.prep_pad = 1'b1;
        state_d        = sts_i.lead_sign ? ST_LEAD : ST_PADPRE;
      end
      ST_LEAD: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_PADPRE;
        end
      end
      ST_PADPRE: begin
        cmd_o.sel = SEL_PAD;
        if (sts_i.pad_before && sts_i.pad_left) begin
          cmd_o.emit = sts_i.out_free;
        end else begin
          state_d = sts_i.inline_sign ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.last = sts_i.dig_last && !sts_i.pad_left;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.dig_last) begin
            state_d = sts_i.pad_left ? ST_PADPOST : ST_IDLE;
          end
        end
      end
      ST_PADPOST: begin
        cmd_o.sel  = SEL_PAD;
        cmd_o.last = sts_i.pad_one;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pad_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/itaf_dpath.sv
// ----------------------------------------------------------------------------
// itaf_dpath
// digit registers, bcd conversion, field counters and output register
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_macros.svh"

module itaf_dpath #(
  parameter int unsigned MAX_FIELD_WIDTH = itaf_pkg::MaxFieldWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itaf_pkg::itaf_in_t  in_data_i,
  input  itaf_pkg::itaf_cmd_t cmd_i,
  output itaf_pkg::itaf_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itaf_pkg::itaf_out_t out_data_o
);
  import itaf_pkg::*;

  localparam int unsigned WW = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int unsigned DW = BcdDigits * 4;
  localparam int unsigned IW = $clog2(BcdDigits);
  localparam int unsigned NW = $clog2(BcdDigits + 1);
  localparam int unsigned CW = $clog2(ConvSteps);

  logic [ValueWidth-1:0]     bin_q;
  logic [BcdDigits-1:0][3:0] dig_q;
  logic [CW-1:0]             conv_cnt_q;
  logic [4:0]                flags_q;
  logic [WW-1:0]             width_q;
  logic                      neg_q;
  logic                      lead_q;
  logic [NW-1:0]             ndig_q;
  logic [IW-1:0]             dig_idx_q;
  logic [WW-1:0]             pad_q;
  logic                      out_valid_q;
  itaf_out_t                 out_q;

  logic                  in_neg;
  logic [ValueWidth-1:0] in_mag;
  logic [WW-1:0]         in_width;
  logic [DW-1:0]         cv_dig;
  logic [ValueWidth-1:0] cv_bin;
  logic [NW-1:0]         ndig_c;
  logic                  lead_c;
  logic [WW-1:0]         len_c;
  logic [3:0]            nib;
  logic [7:0]            char_c;
  logic                  out_free;
  logic                  pad_bad;
  logic                  dig_bad;
  logic [4:0]            cmd_vec;

  // load side
  always_comb begin
    in_neg = in_data_i.format_flags[FlagSigned] && !in_data_i.format_flags[FlagHex] &&
             in_data_i.value[ValueWidth-1];
    in_mag = in_neg ? (ValueWidth'(0) - in_data_i.value) : in_data_i.value;
    if (in_data_i.field_width > 8'(MAX_FIELD_WIDTH)) begin
      in_width = WW'(MAX_FIELD_WIDTH);
    end else begin
      in_width = WW'(in_data_i.field_width);
    end
  end

  // double dabble, four bits per cycle
  always_comb begin
    cv_dig = dig_q;
    cv_bin = bin_q;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int k = 0; k < BcdDigits; k++) begin
        if (cv_dig[k*4 +: 4] >= 4'd5) begin
          cv_dig[k*4 +: 4] = cv_dig[k*4 +: 4] + 4'd3;
        end
      end
      {cv_dig, cv_bin} = {cv_dig[DW-2:0], cv_bin, 1'b0};
    end
  end

  // field setup
  always_comb begin
    ndig_c = NW'(1);
    for (int k = 0; k < BcdDigits; k++) begin
      if (dig_q[k] != 4'd0) begin
        ndig_c = NW'(k + 1);
      end
    end
    lead_c = neg_q && (width_q != '0) && flags_q[FlagPadZero];
    len_c  = WW'(ndig_q) + WW'(neg_q && !lead_q);
  end

  // character select
  always_comb begin
    nib = dig_q[dig_idx_q];
    unique case (cmd_i.sel)
      SEL_SIGN: char_c = CharMinus;
      SEL_PAD:  char_c = flags_q[FlagPadZero] ? CharZero : CharSpace;
      SEL_DIGIT: begin
        if (nib < 4'd10) begin
          char_c = CharZero + 8'(nib);
        end else begin
          char_c = (flags_q[FlagLower] ? CharLowerA : CharUpperA) + 8'(nib) - 8'd10;
        end
      end
      default:  char_c = CharSpace;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        conv_cnt_q <= '0;
      end else if (cmd_i.conv_step) begin
        conv_cnt_q <= conv_cnt_q + CW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      flags_q <= in_data_i.format_flags;
      width_q <= in_width;
      neg_q   <= in_neg;
      if (in_data_i.format_flags[FlagHex]) begin
        dig_q <= DW'(in_data_i.value);
      end else begin
        dig_q <= '0;
      end
      bin_q <= in_mag;
    end
    if (cmd_i.conv_step) begin
      dig_q <= cv_dig;
      bin_q <= cv_bin;
    end
    if (cmd_i.prep_cnt) begin
      ndig_q    <= ndig_c;
      dig_idx_q <= IW'(ndig_c - NW'(1));
      lead_q    <= lead_c;
      width_q   <= width_q - WW'(lead_c);
    end
    if (cmd_i.prep_pad) begin
      pad_q <= (width_q > len_c) ? (width_q - len_c) : '0;
    end
    if (cmd_i.emit) begin
      out_q.out_char  <= char_c;
      out_q.last_char <= cmd_i.last;
      if (cmd_i.sel == SEL_PAD) begin
        pad_q <= pad_q - WW'(1);
      end
      if (cmd_i.sel == SEL_DIGIT) begin
        dig_idx_q <= dig_idx_q - IW'(1);
      end
    end
  end

  always_comb begin
    sts_o.hex         = in_data_i.format_flags[FlagHex];
    sts_o.conv_last   = (conv_cnt_q == CW'(ConvSteps - 1));
    sts_o.lead_sign   = lead_q;
    sts_o.inline_sign = neg_q && !lead_q;
    sts_o.pad_before  = flags_q[FlagPadBefore];
    sts_o.pad_left    = (pad_q != '0);
    sts_o.pad_one     = (pad_q == WW'(1));
    sts_o.dig_last    = (dig_idx_q == '0);
    sts_o.out_free    = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pad_bad = cmd_i.emit && (cmd_i.sel == SEL_PAD) && (pad_q == '0);
  assign dig_bad = cmd_i.emit && (cmd_i.sel == SEL_DIGIT) && (NW'(dig_idx_q) >= ndig_q);
  assign cmd_vec = {cmd_i.load, cmd_i.conv_step, cmd_i.prep_cnt, cmd_i.prep_pad, cmd_i.emit};

  `ITAF_ASSERT(a_emit_free, clk_i, rst_ni, cmd_i.emit |-> out_free, "item loaded into busy output")
  `ITAF_ASSERT_NEVER(a_pad_underflow, clk_i, rst_ni, pad_bad, "pad count underflow")
  `ITAF_ASSERT_NEVER(a_digit_range, clk_i, rst_ni, dig_bad, "digit index out of range")
  `ITAF_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0(cmd_vec), "conflicting datapath commands")

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// An accepted decimal item goes through the bcd conversion (4 bits per cycle), while hex
// items skip it; both then pass the setup states ST_PREP_CNT and ST_PREP_PAD before the
// first character is loaded. Digits and padding go out one character per cycle while the
// output does not stall, and the next item is not accepted until the last character of
// the current one is loaded into the output register.
// Reset: asynchronous active low, returns to idle and drops out_valid_o.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer to ascii text, one character per output item
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_FIELD_WIDTH = itaf_pkg::MaxFieldWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itaf_pkg::itaf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itaf_pkg::itaf_out_t out_data_o
);
  import itaf_pkg::*;

  itaf_cmd_t cmd;
  itaf_sts_t sts;

  itaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itaf_dpath #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Self-checking bench for the printf-style integer formatter. Items carrying
// a 64-bit value, a width and format flags go in, with random gaps on the
// input side and random stalls on the output side. Each accepted item is
// turned into its expected character stream by a local formatter model, and
// every character that comes out is compared against it in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  import itaf_pkg::*;

  localparam int unsigned MaxWidth    = MaxFieldWidthDef;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  itaf_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  itaf_out_t out_data_o;

  itaf_out_t   pending_chars[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          gaps_on;

  integer_to_ascii_formatter #(
    .MAX_FIELD_WIDTH(MaxWidth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // builds the text the formatter must produce for one item
  function automatic void queue_formatted_text(input itaf_in_t item);
    logic [63:0] mag;
    logic [4:0]  flags;
    logic [7:0]  letter;
    logic [7:0]  pad_char;
    logic [7:0]  digit;
    logic [7:0]  body[$];
    logic [7:0]  text[$];
    int unsigned width;
    int unsigned base;
    int unsigned pad;
    itaf_out_t   ch;
    mag      = item.value;
    flags    = item.format_flags;
    width    = item.field_width;
    base     = flags[FlagHex] ? 16 : 10;
    letter   = flags[FlagLower] ? CharLowerA : CharUpperA;
    pad_char = flags[FlagPadZero] ? CharZero : CharSpace;
    if (width > MaxWidth) width = MaxWidth;
    if (mag == 64'd0) begin
      body.push_front(CharZero);
    end else begin
      bit neg;
      neg = flags[FlagSigned] && !flags[FlagHex] && mag[63];
      if (neg) mag = -mag;
      while (mag != 64'd0) begin
        digit = 8'(mag % base);
        mag   = mag / base;
        body.push_front(digit < 10 ? CharZero + digit : letter + digit - 8'd10);
      end
      if (neg) begin
        if (width != 0 && flags[FlagPadZero]) begin
          text.push_back(CharMinus);
          width--;
        end else begin
          body.push_front(CharMinus);
        end
      end
    end
    pad = (body.size() >= width) ? 0 : width - body.size();
    if (flags[FlagPadBefore]) begin
      repeat (pad) text.push_back(pad_char);
      pad = 0;
    end
    foreach (body[i]) text.push_back(body[i]);
    repeat (pad) text.push_back(pad_char);
    foreach (text[i]) begin
      ch.out_char  = text[i];
      ch.last_char = (i == text.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("out_char: expected nothing, actual %h", out_data_o.out_char);
        error_count++;
      end else begin
        itaf_out_t exp_ch;
        exp_ch = pending_chars.pop_front();
        if (out_data_o.out_char !== exp_ch.out_char) begin
          $error("out_char: expected %h, actual %h", exp_ch.out_char, out_data_o.out_char);
          error_count++;
        end
        if (out_data_o.last_char !== exp_ch.last_char) begin
          $error("last_char: expected %b, actual %b", exp_ch.last_char,
                 out_data_o.last_char);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [63:0] value, input logic [7:0] width,
                           input logic [4:0] flags);
    itaf_in_t item;
    item = '{value: value, field_width: width, format_flags: flags};
    if (gaps_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_formatted_text(item);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 4))
      0: return {$urandom(), $urandom()};
      1: return 64'($urandom_range(0, 999));
      2: return -64'($urandom_range(1, 1000));
      3: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [7:0] random_width();
    if ($urandom_range(99) < 10) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, MaxWidth + 4));
  endfunction

  task automatic test_value_extremes();
    send_item(64'd0, 8'd0, 5'b00000);
    send_item(64'd0, 8'd0, 5'b00001);
    send_item('1, 8'd0, 5'b00000);
    send_item('1, 8'd0, 5'b00001);
    send_item('1, 8'd0, 5'b00101);
    send_item('1, 8'd0, 5'b00010);
    send_item(64'h8000_0000_0000_0000, 8'd0, 5'b00010);
    send_item(64'h7fff_ffff_ffff_ffff, 8'd0, 5'b00010);
    send_item(64'hdead_beef_cafe_f00d, 8'd0, 5'b00011);
  endtask

  task automatic test_padding();
    send_item(64'd42, 8'd255, 5'b01000);
    send_item(64'd42, 8'd33, 5'b11000);
    send_item(64'd42, 8'd32, 5'b00000);
    send_item(64'd42, 8'd32, 5'b10000);
    send_item(64'd123456, 8'd1, 5'b11000);
    send_item(64'd0, 8'd5, 5'b10000);
    send_item(64'd0, 8'd5, 5'b11000);
  endtask

  task automatic test_negative_sign();
    send_item(-64'd7, 8'd6, 5'b11010);
    send_item(-64'd7, 8'd6, 5'b10010);
    send_item(-64'd7, 8'd6, 5'b01010);
    send_item(-64'd7, 8'd6, 5'b00010);
    send_item(-64'd7, 8'd0, 5'b11010);
    send_item(-64'd7, 8'd1, 5'b11010);
    send_item(64'h8000_0000_0000_0000, 8'd255, 5'b11010);
  endtask

  task automatic test_random_items(input int unsigned count);
    repeat (count) send_item(random_value(), random_width(), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    error_count = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_value_extremes();
    test_padding();
    test_negative_sign();
    test_random_items(150);
    wait_for_drain();
    gaps_on = 1'b0;
    test_random_items(150);
    gaps_on = 1'b1;
    test_random_items(150);
    wait_for_drain();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/itaf_pkg.sv
rtl/itaf_ctrl.sv
rtl/itaf_dpath.sv
rtl/integer_to_ascii_formatter.sv
verif/tb_integer_to_ascii_formatter.sv
